// ----- hdl/dwm_pkg.sv -----
`timescale 1ns / 1ps
package dwm_pkg;

   localparam int KMER_W = 64;
   localparam int POS_W = 32;
   localparam logic [2:0] CODE_BAD = 3'd4;

   localparam logic [1:0] CSR_KMER = 2'd0;
   localparam logic [1:0] CSR_WINDOW = 2'd1;
   localparam logic [1:0] CSR_SEQ = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [KMER_W-1:0] kmer;
      logic [POS_W-1:0] pos;
   } entry_type;

   function automatic logic [2:0] base_code(input logic [7:0] ch);
      logic [2:0] code;
      case (ch)
         8'd0, 8'h41, 8'h61: code = 3'd0;
         8'd1, 8'h43, 8'h63: code = 3'd1;
         8'd2, 8'h47, 8'h67: code = 3'd2;
         8'd3, 8'h54, 8'h74, 8'h55, 8'h75: code = 3'd3;
         default: code = CODE_BAD;
      endcase
      return code;
   endfunction

endpackage

// ----- hdl/dna_window_minimizer_sketch.sv -----
`timescale 1ns / 1ps
// Result timing: a word that needs no ring rescan gives its result word in the cycle after acceptance.
// Throughput: 1 word per cycle while no result word is made and no rescan runs; a word that
// makes a result holds the input until that result is taken.
// When the running minimum leaves the window a rescan of the ring memory runs through the states
// SCAN_RD, SCAN and OUT, reading one entry per cycle through the single read port.
// Reset: synchronous, active high; clears control state and sets registers to k=15, w=10, id=0.
module dna_window_minimizer_sketch #(
   parameter int MAX_WINDOW = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_base_char,
   input  logic req_first_base,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [61:0] rsp_minimizer_kmer,
   output logic rsp_minimizer_strand,
   output logic [31:0] rsp_minimizer_position,
   output logic [31:0] rsp_minimizer_sequence,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int SW = $clog2(MAX_WINDOW + 31);

   logic [4:0] kreg_ff;
   logic [6:0] wreg_ff;
   logic [31:0] seq_ff;

   logic [63:0] fwd_ff, fwd_in, rev_ff, rev_in, act_k_ff, act_k_in;
   logic [31:0] act_p_ff, act_p_in, cnt_ff, cnt_in;
   logic [SW-1:0] clean_ff, clean_in;
   dwm_pkg::state_type state_ff, state_in;
   logic [WW-1:0] scan_ff, scan_in;
   logic emit_ff, emit_in;
   logic out_v_ff;
   logic [63:0] out_k_ff;
   logic [31:0] out_p_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   dwm_pkg::entry_type wr_data, rd_data;

   dwm_ring #(.DEPTH(MAX_WINDOW), .AW(AW)) u_ring (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   // effective k and w
   logic [4:0] k;
   logic [WW-1:0] w;
   logic [SW-1:0] span;
   always_comb begin
      k = (kreg_ff == 5'd0) ? 5'd1 : kreg_ff;
      if (wreg_ff == 7'd0) w = WW'(1);
      else if ({25'd0, wreg_ff} > MAX_WINDOW) w = WW'(MAX_WINDOW);
      else w = WW'(wreg_ff);
      span = SW'(w) + SW'(k) - SW'(1);
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         kreg_ff <= 5'd15;
         wreg_ff <= 7'd10;
         seq_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            dwm_pkg::CSR_KMER: kreg_ff <= csr_data[4:0];
            dwm_pkg::CSR_WINDOW: wreg_ff <= csr_data[6:0];
            dwm_pkg::CSR_SEQ: seq_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic accept;
   assign req_stall = (state_ff != dwm_pkg::ST_IDLE) || out_v_ff;
   assign accept = req_valid && !req_stall;

   // per-word datapath
   logic [2:0] c;
   logic [31:0] n, q, nb_cnt;
   logic [63:0] f0, r0, a0, mask, fnew, rnew, can, bk, vv;
   logic [61:0] rc_all;
   logic [31:0] ap0;
   logic [SW-1:0] cl0, clnew;
   logic clean, expire, smaller, have_kmer;
   always_comb begin
      c = dwm_pkg::base_code(req_base_char);
      f0 = req_first_base ? 64'd0 : fwd_ff;
      r0 = req_first_base ? 64'd0 : rev_ff;
      a0 = req_first_base ? 64'd0 : act_k_ff;
      ap0 = req_first_base ? 32'd0 : act_p_ff;
      n = req_first_base ? 32'd0 : cnt_ff;
      cl0 = req_first_base ? '0 : clean_ff;
      nb_cnt = n + 32'd1;
      have_kmer = n >= ({27'd0, k} - 32'd1);
      if (c != dwm_pkg::CODE_BAD) clnew = (cl0 >= span) ? span : cl0 + SW'(1);
      else clnew = '0;
      clean = clnew >= span;
      mask = (64'd1 << {k, 1'b0}) - 64'd1;
      bk = '0;
      rc_all = '0;
      if (n < {27'd0, k}) begin
         fnew = ((((f0 >> 1) << 2) + {61'd0, c}) << 1);
         vv = fnew >> 1;
         // complement and reverse all 31 fields, then drop the ones beyond k
         for (int j = 0; j < 31; j++) begin
            rc_all[2*j +: 2] = vv[2*(30-j) +: 2] ^ 2'b11;
         end
         bk = {2'b00, rc_all} >> {5'd31 - k, 1'b0};
         rnew = (bk << 1) | 64'd1;
      end else begin
         fnew = (((((f0 >> 1) << 2) & mask) + {61'd0, c}) << 1);
         vv = (r0 >> 3) | ({61'd0, 3'd3 ^ c} << {k - 5'd1, 1'b0});
         rnew = (vv << 1) | 64'd1;
      end
      can = ({fnew[63:1], 1'b0} < {rnew[63:1], 1'b0}) ? fnew : rnew;
      q = n - {27'd0, k} + 32'd1;
      expire = (q - {{(32-WW){1'b0}}, w}) >= ap0;
      smaller = {can[63:1], 1'b0} < {a0[63:1], 1'b0};
   end

   // slot counter tracks q mod w
   logic [WW-1:0] slot_ff, slot_in;
   logic [WW-1:0] slot_now;
   always_comb begin
      slot_now = (n < {27'd0, k} || n == {27'd0, k} - 32'd1) ? '0 : slot_ff;
      if (n + 32'd1 == {27'd0, k}) slot_now = '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dwm_pkg::ST_IDLE:
            if (accept && have_kmer && q >= {{(32-WW){1'b0}}, w} && expire)
               state_in = dwm_pkg::ST_SCAN_RD;
         dwm_pkg::ST_SCAN_RD: state_in = dwm_pkg::ST_SCAN;
         dwm_pkg::ST_SCAN: if (scan_ff == w) state_in = dwm_pkg::ST_OUT;
         dwm_pkg::ST_OUT: state_in = dwm_pkg::ST_IDLE;
         default: state_in = dwm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      fwd_in = fwd_ff; rev_in = rev_ff; act_k_in = act_k_ff; act_p_in = act_p_ff;
      cnt_in = cnt_ff; clean_in = clean_ff; slot_in = slot_ff; scan_in = scan_ff;
      emit_in = emit_ff;
      wr_en = 1'b0; wr_addr = slot_now[AW-1:0];
      wr_data.kmer = can; wr_data.pos = q;
      rd_addr = scan_ff[AW-1:0];
      if (accept) begin
         fwd_in = fnew; rev_in = rnew; cnt_in = nb_cnt; clean_in = clnew;
         act_k_in = a0; act_p_in = ap0; emit_in = 1'b0;
         if (have_kmer) begin
            wr_en = 1'b1;
            slot_in = (slot_now + WW'(1) == w) ? '0 : slot_now + WW'(1);
            if (q == 32'd0) begin
               act_k_in = can; act_p_in = 32'd0; emit_in = (w == WW'(1)) && clean;
            end else if (q < {{(32-WW){1'b0}}, w}) begin
               if (smaller) begin act_k_in = can; act_p_in = q; end
               emit_in = (q == {{(32-WW){1'b0}}, w} - 32'd1) && clean;
            end else if (expire) begin
               scan_in = '0; emit_in = clean;
            end else if (smaller) begin
               act_k_in = can; act_p_in = q; emit_in = clean;
            end
         end
      end
      if (state_ff == dwm_pkg::ST_SCAN_RD) begin
         scan_in = WW'(1); rd_addr = '0;
      end else if (state_ff == dwm_pkg::ST_SCAN) begin
         rd_addr = scan_ff[AW-1:0];
         if (scan_ff == WW'(1) ||
             {rd_data.kmer[63:1], 1'b0} < {act_k_ff[63:1], 1'b0}) begin
            act_k_in = rd_data.kmer; act_p_in = rd_data.pos;
         end
         scan_in = scan_ff + WW'(1);
      end
   end

   logic load_out;
   assign load_out = (state_ff == dwm_pkg::ST_IDLE && state_in == dwm_pkg::ST_IDLE
                      && accept && emit_in) ||
                     (state_ff == dwm_pkg::ST_OUT && emit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwm_pkg::ST_IDLE;
         fwd_ff <= '0; rev_ff <= '0; act_k_ff <= '0; act_p_ff <= '0;
         cnt_ff <= '0; clean_ff <= '0; slot_ff <= '0; scan_ff <= '0;
         emit_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fwd_ff <= fwd_in; rev_ff <= rev_in; act_k_ff <= act_k_in; act_p_ff <= act_p_in;
         cnt_ff <= cnt_in; clean_ff <= clean_in; slot_ff <= slot_in; scan_ff <= scan_in;
         emit_ff <= emit_in;
         if (load_out) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_k_ff <= act_k_in;
         out_p_ff <= act_p_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_minimizer_kmer = out_k_ff[62:1];
   assign rsp_minimizer_strand = out_k_ff[0];
   assign rsp_minimizer_position = out_p_ff;
   assign rsp_minimizer_sequence = seq_ff;

   // scan pointer never passes the window length
   assert property (@(posedge clock) disable iff (reset)
      state_ff == dwm_pkg::ST_SCAN |-> scan_ff <= w)
      else $error("scan overrun");
   // no word is taken during a rescan
   assert property (@(posedge clock) disable iff (reset)
      state_ff != dwm_pkg::ST_IDLE |-> req_stall)
      else $error("accept during scan");
   // a result word appears only after an update or a finished scan
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(accept) || $past(state_ff) == dwm_pkg::ST_OUT))
      else $error("spurious result");

endmodule

// ----- hdl/dwm_ring.sv -----
`timescale 1ns / 1ps
module dwm_ring #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  dwm_pkg::entry_type wr_data,
   input  logic [AW-1:0] rd_addr,
   output dwm_pkg::entry_type rd_data
);

   dwm_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

   typedef struct {
      logic [7:0] base_char;
      logic first_base;
   } base_word_type;

   typedef struct {
      logic [61:0] kmer;
      logic strand;
      logic [31:0] position;
      logic [31:0] sequence_id;
   } minimizer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_base_char = '0;
   logic req_first_base = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [61:0] rsp_minimizer_kmer;
   logic rsp_minimizer_strand;
   logic [31:0] rsp_minimizer_position;
   logic [31:0] rsp_minimizer_sequence;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   dna_window_minimizer_sketch u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   base_word_type pending_bases[$];
   minimizer_type expected_minimizers[$];
   int errors = 0;
   int words_sent = 0;
   int hold_cycles = 0;
   bit hold_done = 0;
   int quiet_cycles = 0;

   // predictor state
   logic [4:0] cfg_kmer = 5'd15;
   logic [6:0] cfg_window = 7'd10;
   logic [31:0] cfg_seq = '0;
   logic [63:0] fwd_kmer, rev_kmer, min_kmer;
   logic [63:0] ring_kmer[64];
   logic [31:0] ring_pos[64];
   logic [31:0] min_pos, base_cnt, clean_cnt;

   function automatic void queue_base(input logic [7:0] ch, input bit first);
      base_word_type b;
      b.base_char = ch;
      b.first_base = first;
      pending_bases.insert(pending_bases.size(), b);
   endfunction

   function automatic logic [63:0] even(input logic [63:0] v);
      return {v[63:1], 1'b0};
   endfunction

   function automatic void clear_track();
      fwd_kmer = '0;
      rev_kmer = '0;
      min_kmer = '0;
      min_pos = '0;
      base_cnt = '0;
      clean_cnt = '0;
   endfunction

   function automatic void predict_minimizer(input base_word_type b);
      int unsigned k, w, span, n, q, slot;
      logic [63:0] code, mask, can, v, rc;
      bit clean, hit;
      minimizer_type m;
      hit = 0;
      k = (cfg_kmer == 0) ? 1 : cfg_kmer;
      w = (cfg_window == 0) ? 1 : (cfg_window > 64) ? 64 : cfg_window;
      span = w + k - 1;
      if (b.first_base) clear_track();
      case (b.base_char)
         8'd0, "A", "a": code = 0;
         8'd1, "C", "c": code = 1;
         8'd2, "G", "g": code = 2;
         8'd3, "T", "t", "U", "u": code = 3;
         default: code = 4;
      endcase
      n = base_cnt;
      base_cnt = n + 1;
      if (code < 4) clean_cnt = (clean_cnt >= span) ? span : clean_cnt + 1;
      else clean_cnt = 0;
      clean = clean_cnt >= span;
      mask = (64'd1 << (2 * k)) - 1;
      if (n < k) begin
         fwd_kmer = (((fwd_kmer >> 1) << 2) + code) << 1;
         if (n + 1 < k) return;
         v = fwd_kmer >> 1;
         rc = '0;
         for (int j = 0; j < k; j++) begin
            rc = (rc << 2) + ((v & 64'd3) ^ 64'd3);
            v = v >> 2;
         end
         rev_kmer = (rc << 1) | 64'd1;
      end else begin
         fwd_kmer = ((((fwd_kmer >> 1) << 2) & mask) + code) << 1;
         v = (rev_kmer >> 3) | ((64'd3 ^ code) << (2 * (k - 1)));
         rev_kmer = (v << 1) | 64'd1;
      end
      can = (even(fwd_kmer) < even(rev_kmer)) ? fwd_kmer : rev_kmer;
      q = n - k + 1;
      slot = q % w;
      ring_kmer[slot] = can;
      ring_pos[slot] = q;
      if (q == 0) begin
         min_kmer = can;
         min_pos = 0;
         hit = (w == 1) && clean;
      end else if (q < w) begin
         if (even(can) < even(min_kmer)) begin
            min_kmer = can;
            min_pos = q;
         end
         hit = (q == w - 1) && clean;
      end else if (q - w >= min_pos) begin
         // minimum expired: rescan, lowest slot wins ties
         min_kmer = ring_kmer[0];
         min_pos = ring_pos[0];
         for (int j = 1; j < w; j++)
            if (even(ring_kmer[j]) < even(min_kmer)) begin
               min_kmer = ring_kmer[j];
               min_pos = ring_pos[j];
            end
         hit = clean;
      end else if (even(can) < even(min_kmer)) begin
         min_kmer = can;
         min_pos = q;
         hit = clean;
      end
      if (hit) begin
         m.kmer = min_kmer[62:1];
         m.strand = min_kmer[0];
         m.position = min_pos;
         m.sequence_id = cfg_seq;
         expected_minimizers.insert(expected_minimizers.size(), m);
      end
   endfunction

   // no idling in the middle stretch
   function automatic bit calm();
      return words_sent >= 1000 && words_sent < 1300;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_minimizer('{req_base_char, req_first_base});
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_bases.size() == 0 || (!calm() && $urandom_range(99) < 20)) begin
               req_valid <= 1'b0;
            end else begin
               base_word_type b;
               b = pending_bases.pop_front();
               req_base_char <= b.base_char;
               req_first_base <= b.first_base;
               req_valid <= 1'b1;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_minimizers.size() == 0) begin
               $display("%0t: unexpected word kmer %h pos %0d", $realtime,
                        rsp_minimizer_kmer, rsp_minimizer_position);
               errors++;
            end else begin
               minimizer_type m;
               m = expected_minimizers.pop_front();
               if (rsp_minimizer_kmer !== m.kmer) begin
                  $display("%0t: kmer exp %h got %h", $realtime, m.kmer, rsp_minimizer_kmer);
                  errors++;
               end
               if (rsp_minimizer_strand !== m.strand) begin
                  $display("%0t: strand exp %0d got %0d", $realtime, m.strand,
                           rsp_minimizer_strand);
                  errors++;
               end
               if (rsp_minimizer_position !== m.position) begin
                  $display("%0t: position exp %0d got %0d", $realtime, m.position,
                           rsp_minimizer_position);
                  errors++;
               end
               if (rsp_minimizer_sequence !== m.sequence_id) begin
                  $display("%0t: sequence exp %h got %h", $realtime, m.sequence_id,
                           rsp_minimizer_sequence);
                  errors++;
               end
            end
         end
         // long hold-off so the block backs up and stalls its input
         if (!hold_done && words_sent >= 600) begin
            hold_done = 1;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) hold_cycles--;
         rsp_stall <= hold_cycles > 0 || (!calm() && $urandom_range(99) < 20);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic set_regs(input logic [4:0] k, input logic [6:0] w, input logic [31:0] id);
      logic [1:0] idx[3];
      logic [31:0] val[3];
      idx = '{dwm_pkg::CSR_KMER, dwm_pkg::CSR_WINDOW, dwm_pkg::CSR_SEQ};
      val = '{{27'd0, k}, {25'd0, w}, id};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            dwm_pkg::CSR_KMER: cfg_kmer = val[i][4:0];
            dwm_pkg::CSR_WINDOW: cfg_window = val[i][6:0];
            default: cfg_seq = val[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_bases.size() != 0 || expected_minimizers.size() != 0 || req_valid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [7:0] random_base(input bit dirty);
      logic [7:0] letters[14];
      letters = '{"A", "a", "C", "c", "G", "g", "T", "t", "U", "u", 8'd0, 8'd1, 8'd2, 8'd3};
      if (dirty && $urandom_range(99) < 6)
         return ($urandom_range(1)) ? "N" : 8'($urandom);
      return letters[$urandom_range(13)];
   endfunction

   task automatic queue_random(input int count);
      int left, len;
      bit dirty;
      left = count;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 70);
         if (len > left) len = left;
         dirty = $urandom_range(1);
         for (int i = 0; i < len; i++)
            queue_base(random_base(dirty), i == 0);
         left -= len;
      end
   endtask

   initial begin
      logic [7:0] directed[24];
      logic [4:0] ks[8];
      logic [6:0] ws[8];
      logic [31:0] ids[8];
      directed = '{"A", "a", "C", "c", "G", "g", "T", "t", "U", "u", 8'd0, 8'd1,
                   8'd2, 8'd3, "N", 8'hFF, "A", "C", "G", "T", "T", "G", "C", "A"};
      ks = '{5'd15, 5'd1, 5'd31, 5'd0, 5'd4, 5'd2, 5'd7, 5'd31};
      ws = '{7'd10, 7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd5, 7'd2};
      ids = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A,
              32'h0000_0001, 32'h8000_0000, 32'hDEAD_BEEF, 32'h5555_AAAA};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_regs(5'd2, 7'd2, 32'hFFFF_FFFF);
      foreach (directed[i]) queue_base(directed[i], i == 0);
      queue_base("G", 1'b1);
      drain();
      for (int p = 0; p < 8; p++) begin
         set_regs(ks[p], ws[p], ids[p]);
         queue_random(240);
         drain();
      end
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
